>>> sv/spof_pkg.sv
package spof_pkg;

  // Default depth of the source prefix store and the sink window.
  localparam int DEF_MAX_WINDOW = 64;

  // Largest overlap length that the result word can report.
  localparam int OUT_LEN_MAX = 63;

  // Field widths.
  localparam int SYM_W     = 8;
  localparam int LEN_W     = 7;
  localparam int OLEN_W    = 6;
  localparam int CFG_IDX_W = 2;

  // Input word commands.
  localparam logic CMD_SOURCE = 1'b0;
  localparam logic CMD_SINK   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_HI = 2'd1;

  // Configuration reset values.
  localparam logic [LEN_W-1:0] LEN_LO_RST = 7'd1;
  localparam logic [LEN_W-1:0] LEN_HI_RST = 7'd20;

  // Input word.
  typedef struct packed {
    logic             command;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [OLEN_W-1:0] overlap_length;
    logic              found;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_open;     // input channel may take a word
    logic len_init;    // load the first length to try
    logic len_setup;   // point the read addresses at the current length
    logic rd_step;     // advance both read addresses
    logic p_inc;       // move to the next compared position
    logic len_inc;     // try the next length
    logic res_set;     // capture the search outcome
    logic res_hit;     // outcome is a match at the current length
    logic out_load;    // move the outcome into the output register
    logic sink_clear;  // sink sequence finished
  } spof_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start;         // last sink symbol accepted
    logic len_ge_max;    // current length has reached the upper bound
    logic len_gt_limit;  // current length exceeds the stored data or OUT_LEN_MAX
    logic len_zero;      // current length is zero
    logic sym_eq;        // compared symbols are equal
    logic p_last;        // compared position is the final one of this length
    logic out_free;      // output register can take a word this cycle
  } spof_sts_t;

endpackage

>>> sv/spof_ctrl.sv
module spof_ctrl
  import spof_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  spof_sts_t sts,
  output spof_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LEN  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.in_open = 1'b1;
        if (sts.start) begin
          cmd.len_init = 1'b1;
          state_nxt    = ST_LEN;
        end
      end
      ST_LEN: begin
        if (sts.len_ge_max || sts.len_gt_limit || sts.len_zero) begin
          cmd.res_set = 1'b1;
          state_nxt   = ST_OUT;
        end else begin
          cmd.len_setup = 1'b1;
          state_nxt     = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd_step = 1'b1;
        state_nxt   = ST_CMP;
      end
      ST_CMP: begin
        cmd.rd_step = 1'b1;
        if (!sts.sym_eq) begin
          cmd.len_inc = 1'b1;
          state_nxt   = ST_LEN;
        end else if (sts.p_last) begin
          cmd.res_set = 1'b1;
          cmd.res_hit = 1'b1;
          state_nxt   = ST_OUT;
        end else begin
          cmd.p_inc = 1'b1;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.sink_clear = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/spof_dpath.sv
module spof_dpath
  import spof_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  in_word_t             in_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data,
  input  spof_cmd_t            cmd,
  output spof_sts_t            sts
);

  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int XW    = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  localparam logic [CNT_W-1:0] WIN_CNT   = CNT_W'(MAX_WINDOW);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(MAX_WINDOW - 1);
  localparam logic [XW-1:0]    WIN_X     = XW'(MAX_WINDOW);
  localparam logic [XW-1:0]    OUT_MAX_X = XW'(OUT_LEN_MAX);

  // Buffers.
  logic [SYM_W-1:0] src_mem [MAX_WINDOW];
  logic [SYM_W-1:0] snk_mem [MAX_WINDOW];

  logic [LEN_W-1:0]  min_r, max_r;
  logic [CNT_W-1:0]  src_cnt_r, src_cnt_nxt;
  logic              src_closed_r;
  logic [CNT_W-1:0]  snk_cnt_r, snk_cnt_nxt;
  logic [AW-1:0]     wptr_r;
  logic [AW-1:0]     src_addr_r;
  logic [AW-1:0]     snk_addr_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  p_r;
  logic [SYM_W-1:0]  src_rd_r, snk_rd_r;
  logic [OLEN_W-1:0] res_len_r;
  logic              res_hit_r;
  logic              out_valid_r;
  out_word_t         out_data_r;

  logic             in_acc;
  logic             src_wr;
  logic             snk_wr;
  logic [AW-1:0]    src_wr_addr;
  logic [XW-1:0]    src_x, snk_x, lim_a, limit_x, len_x, sum_x, start_x;
  logic [AW-1:0]    wptr_inc, snk_addr_inc;

  // Input acceptance and buffer write enables.
  assign in_acc      = in_valid && cmd.in_open;
  assign src_wr      = in_acc && (in_data.command == CMD_SOURCE) &&
                       (src_closed_r || (src_cnt_r < WIN_CNT));
  assign snk_wr      = in_acc && (in_data.command == CMD_SINK);
  assign src_wr_addr = src_closed_r ? '0 : src_cnt_r[AW-1:0];

  // A closed source restarts from the beginning; surplus symbols are dropped.
  always_comb begin
    src_cnt_nxt = src_cnt_r;
    if (in_acc && (in_data.command == CMD_SOURCE)) begin
      if (src_closed_r) begin
        src_cnt_nxt = CNT_W'(1);
      end else if (src_cnt_r < WIN_CNT) begin
        src_cnt_nxt = src_cnt_r + CNT_W'(1);
      end
    end
  end

  // The sink count saturates at the window depth and clears after a search.
  always_comb begin
    snk_cnt_nxt = snk_cnt_r;
    if (cmd.sink_clear) begin
      snk_cnt_nxt = '0;
    end else if (snk_wr && (snk_cnt_r < WIN_CNT)) begin
      snk_cnt_nxt = snk_cnt_r + CNT_W'(1);
    end
  end

  // Circular address increments.
  assign wptr_inc     = (wptr_r == LAST_ADDR) ? '0 : wptr_r + AW'(1);
  assign snk_addr_inc = (snk_addr_r == LAST_ADDR) ? '0 : snk_addr_r + AW'(1);

  // Longest length the stored data and the result width allow.
  assign src_x   = XW'(src_cnt_r);
  assign snk_x   = XW'(snk_cnt_r);
  assign lim_a   = (src_x < snk_x) ? src_x : snk_x;
  assign limit_x = (lim_a > OUT_MAX_X) ? OUT_MAX_X : lim_a;
  assign len_x   = XW'(len_r);

  // Oldest sink symbol of the current length, counted back from the write pointer.
  assign sum_x   = XW'(wptr_r) + (WIN_X - len_x);
  assign start_x = (sum_x >= WIN_X) ? (sum_x - WIN_X) : sum_x;

  // Status towards the controller.
  always_comb begin
    sts.start        = in_acc && (in_data.command == CMD_SINK) && in_data.last;
    sts.len_ge_max   = (len_r >= max_r);
    sts.len_gt_limit = (len_x > limit_x);
    sts.len_zero     = (len_r == '0);
    sts.sym_eq       = (src_rd_r == snk_rd_r);
    sts.p_last       = (p_r == (len_r - LEN_W'(1)));
    sts.out_free     = !out_valid_r || !out_stall;
  end

  // Source prefix store.
  always_ff @(posedge clk) begin
    if (src_wr) begin
      src_mem[src_wr_addr] <= in_data.symbol;
    end
    src_rd_r <= src_mem[src_addr_r];
  end

  // Sink window store.
  always_ff @(posedge clk) begin
    if (snk_wr) begin
      snk_mem[wptr_r] <= in_data.symbol;
    end
    snk_rd_r <= snk_mem[snk_addr_r];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= LEN_LO_RST;
      max_r <= LEN_HI_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_LEN_LO) begin
        min_r <= cfg_data;
      end
      if (cfg_index == CFG_LEN_HI) begin
        max_r <= cfg_data;
      end
    end
  end

  // Sequence bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r    <= '0;
      src_closed_r <= 1'b0;
      snk_cnt_r    <= '0;
      wptr_r       <= '0;
    end else begin
      src_cnt_r <= src_cnt_nxt;
      snk_cnt_r <= snk_cnt_nxt;
      if (in_acc && (in_data.command == CMD_SOURCE)) begin
        src_closed_r <= in_data.last;
      end
      if (snk_wr) begin
        wptr_r <= wptr_inc;
      end
    end
  end

  // Search counters and read addresses.
  always_ff @(posedge clk) begin
    if (cmd.len_init) begin
      len_r <= min_r;
    end else if (cmd.len_inc) begin
      len_r <= len_r + LEN_W'(1);
    end
    if (cmd.len_setup) begin
      p_r        <= '0;
      src_addr_r <= '0;
      snk_addr_r <= start_x[AW-1:0];
    end else begin
      if (cmd.p_inc) begin
        p_r <= p_r + LEN_W'(1);
      end
      if (cmd.rd_step) begin
        src_addr_r <= (src_addr_r == LAST_ADDR) ? '0 : src_addr_r + AW'(1);
        snk_addr_r <= snk_addr_inc;
      end
    end
  end

  // Search outcome.
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_hit_r <= cmd.res_hit;
      res_len_r <= cmd.res_hit ? len_r[OLEN_W-1:0] : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.overlap_length <= res_len_r;
      out_data_r.found          <= res_hit_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/suffix_prefix_overlap_finder_unit.sv
// Suffix/prefix overlap finder.
// The input channel (in_valid, in_stall, in_data) takes one word per cycle
// while in_stall is low: a source symbol (command 0) or a sink symbol
// (command 1), with last marking the end of a sequence. The first MAX_WINDOW
// source symbols and the latest MAX_WINDOW sink symbols are held in two buffers.
// The word that carries the last sink symbol starts a search; in_stall stays
// high until the result has been placed in the output register. Each length
// tried is set up, read and then compared symbol by symbol, since one symbol
// pair is read from the two buffer ports each cycle; a length that is out of
// range ends the search, and the result then moves to the output register.
// Every other word is taken without a stall.
// The result channel (out_valid, out_stall, out_data) carries one word per
// search. While out_stall is high the output word holds and the next search
// waits at its end; loading symbols continues only until that search starts.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready.
// Reset clears the stored counts, sets the shortest length tried to 1 and
// the exclusive length bound to 20; buffer contents are not cleared.
module suffix_prefix_overlap_finder_unit
  import spof_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data
);

  spof_cmd_t cmd;
  spof_sts_t sts;

  // Words are refused while a search runs.
  assign in_stall  = !cmd.in_open;
  assign cfg_ready = 1'b1;

  spof_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  spof_dpath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
